// File: sv/lfsp_pkg.sv
// ----------------------------------------------------------------------------
// LED frame snapshot publisher package
// Item types, register indexes, reset values and the tag that follows an
// item from the control stage to the result stage.
// ----------------------------------------------------------------------------
package lfsp_pkg;

  localparam int PIXEL_W = 24;

  typedef enum logic [1:0] {
    FUNC_REQUEST = 2'd0,
    FUNC_SHOW    = 2'd1,
    FUNC_PIXEL   = 2'd2,
    FUNC_READ    = 2'd3
  } func_e;

  localparam logic [2:0] CFG_BASE_BRIGHTNESS  = 3'd0;
  localparam logic [2:0] CFG_FADE_LEVEL       = 3'd1;
  localparam logic [2:0] CFG_BOOT_ID          = 3'd2;
  localparam logic [2:0] CFG_REQUEST_TIMEOUT  = 3'd3;
  localparam logic [2:0] CFG_PUBLISH_INTERVAL = 3'd4;

  localparam logic [7:0]  RST_BASE_BRIGHTNESS  = 8'd40;
  localparam logic [7:0]  RST_FADE_LEVEL       = 8'd255;
  localparam logic [31:0] RST_BOOT_ID          = 32'd1;
  localparam logic [15:0] RST_REQUEST_TIMEOUT  = 16'd5000;
  localparam logic [15:0] RST_PUBLISH_INTERVAL = 16'd250;

  localparam logic [16:0] BRIGHT_ROUND = 17'd127;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic [4:0]  read_col;
    logic [2:0]  read_row;
  } in_item_t;

  typedef struct packed {
    logic        ready_res;
    logic [31:0] sequence_res;
    logic [31:0] epoch;
    logic [7:0]  scaled_bright;
    logic        capture_started;
    logic [7:0]  read_red;
    logic [7:0]  read_green;
    logic [7:0]  read_blue;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  base_brightness;
    logic [7:0]  fade_level;
    logic [31:0] boot_id;
    logic [15:0] request_timeout_ms;
    logic [15:0] publish_interval_ms;
  } cfg_t;

  // Per-item information handed from the control stage to the result stage.
  typedef struct packed {
    func_e              func;
    logic               ready_res;
    logic               front;
    logic               start;
    logic               pix_en;
    logic               pix_last;
    logic               ready_before;
    logic [PIXEL_W-1:0] rgb;
    logic               rd_hit;
  } tag_t;

endpackage

// File: sv/lfsp_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface lfsp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: sv/lfsp_frame_mem.sv
// ----------------------------------------------------------------------------
// Frame memory
// Both pixel buffers in one synchronous RAM, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module lfsp_frame_mem import lfsp_pkg::*; #(
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [PIXEL_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [PIXEL_W-1:0] rdata_o
);

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/lfsp_ctrl.sv
// ----------------------------------------------------------------------------
// Capture control
// Viewer and capture state, pixel unscrambling into buffer addresses, and
// the clearing sweep of the frame memory after reset.
// ----------------------------------------------------------------------------
module lfsp_ctrl import lfsp_pkg::*; #(
  parameter int COLUMNS = 32,
  parameter int ROWS = 8,
  localparam int AW = $clog2(2 * COLUMNS * ROWS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  in_item_t           item_i,
  input  cfg_t               cfg_i,
  output logic               clear_busy_o,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output logic [PIXEL_W-1:0] mem_wdata_o,
  output logic               mem_re_o,
  output logic [AW-1:0]      mem_raddr_o,
  output tag_t               tag_o
);

  localparam int NPIX = COLUMNS * ROWS;
  localparam int PW = $clog2(NPIX);
  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  logic          viewer_active_q, viewer_active_d;
  logic          ready_q, ready_d;
  logic [31:0]   last_req_q, last_req_d;
  logic [31:0]   last_pub_q, last_pub_d;
  logic          capture_q, capture_d;
  logic [31:0]   capture_time_q, capture_time_d;
  logic          front_q, front_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [PW-1:0] row_base_q, row_base_d;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  func_e              func;
  logic [31:0]        since_req;
  logic [31:0]        since_pub;
  logic               req_late;
  logic               req_expired;
  logic               start;
  logic [CW-1:0]      x;
  logic [PW-1:0]      pos;
  logic               pix_last;
  logic               pix_en;
  logic [AW-1:0]      front_addr;
  logic [AW-1:0]      back_addr;
  logic               rd_hit;
  logic [AW-1:0]      rd_addr;
  logic [PIXEL_W-1:0] rgb;

  assign func        = func_e'(item_i.func);
  assign since_req   = item_i.now_ms - last_req_q;
  assign since_pub   = item_i.now_ms - last_pub_q;
  assign req_late    = since_req > 32'(cfg_i.request_timeout_ms);
  assign req_expired = !viewer_active_q || req_late;
  assign start       = viewer_active_q && !req_late &&
                       (!ready_q || since_pub >= 32'(cfg_i.publish_interval_ms));

  // Odd rows of the chain run right to left.
  assign x        = row_q[0] ? (CW'(COLUMNS - 1) - col_q) : col_q;
  assign pos      = row_base_q + PW'(x);
  assign pix_last = (row_q == RW'(ROWS - 1)) && (col_q == CW'(COLUMNS - 1));
  assign pix_en   = capture_q;
  assign rgb      = {item_i.pixel_red, item_i.pixel_green, item_i.pixel_blue};

  assign front_addr = AW'(pos) + (front_q ? AW'(NPIX) : AW'(0));
  assign back_addr  = AW'(pos) + (front_q ? AW'(0) : AW'(NPIX));

  assign rd_hit  = (32'(item_i.read_col) < 32'(COLUMNS)) &&
                   (32'(item_i.read_row) < 32'(ROWS));
  assign rd_addr = AW'(item_i.read_row) * AW'(COLUMNS) + AW'(item_i.read_col) +
                   (front_q ? AW'(NPIX) : AW'(0));

  // The back buffer is written as the item is taken; the front entry is read
  // in the same cycle, and the registered read data is compared in the result stage.
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = back_addr;
    mem_wdata_o = rgb;
    if (clr_busy_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = clr_addr_q;
      mem_wdata_o = '0;
    end else if (accept_i && func == FUNC_PIXEL && pix_en) begin
      mem_we_o = 1'b1;
    end
  end

  assign mem_re_o    = accept_i;
  assign mem_raddr_o = (func == FUNC_READ) ? rd_addr : front_addr;

  always_comb begin
    tag_o.func         = func;
    tag_o.ready_res    = req_expired ? 1'b0 : ready_q;
    tag_o.front        = front_q;
    tag_o.start        = start;
    tag_o.pix_en       = pix_en;
    tag_o.pix_last     = pix_last;
    tag_o.ready_before = ready_q;
    tag_o.rgb          = rgb;
    tag_o.rd_hit       = rd_hit;
  end

  always_comb begin
    viewer_active_d = viewer_active_q;
    ready_d         = ready_q;
    last_req_d      = last_req_q;
    last_pub_d      = last_pub_q;
    capture_d       = capture_q;
    capture_time_d  = capture_time_q;
    front_d         = front_q;
    col_d           = col_q;
    row_d           = row_q;
    row_base_d      = row_base_q;
    if (accept_i) begin
      unique case (func)
        FUNC_REQUEST: begin
          if (req_expired) begin
            ready_d = 1'b0;
          end
          viewer_active_d = 1'b1;
          last_req_d      = item_i.now_ms;
        end
        FUNC_SHOW: begin
          if (start) begin
            capture_d      = 1'b1;
            capture_time_d = item_i.now_ms;
            col_d          = '0;
            row_d          = '0;
            row_base_d     = '0;
          end
        end
        FUNC_PIXEL: begin
          if (pix_en) begin
            if (pix_last) begin
              front_d    = !front_q;
              ready_d    = 1'b1;
              last_pub_d = capture_time_q;
              capture_d  = 1'b0;
              col_d      = '0;
              row_d      = '0;
              row_base_d = '0;
            end else if (col_q == CW'(COLUMNS - 1)) begin
              col_d      = '0;
              row_d      = row_q + RW'(1);
              row_base_d = row_base_q + PW'(COLUMNS);
            end else begin
              col_d = col_q + CW'(1);
            end
          end
        end
        FUNC_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      viewer_active_q <= 1'b0;
      ready_q         <= 1'b0;
      last_req_q      <= '0;
      last_pub_q      <= '0;
      capture_q       <= 1'b0;
      capture_time_q  <= '0;
      front_q         <= 1'b0;
      col_q           <= '0;
      row_q           <= '0;
      row_base_q      <= '0;
    end else begin
      viewer_active_q <= viewer_active_d;
      ready_q         <= ready_d;
      last_req_q      <= last_req_d;
      last_pub_q      <= last_pub_d;
      capture_q       <= capture_d;
      capture_time_q  <= capture_time_d;
      front_q         <= front_d;
      col_q           <= col_d;
      row_q           <= row_d;
      row_base_q      <= row_base_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(2 * NPIX - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign clear_busy_o = clr_busy_q;

endmodule

// File: sv/lfsp_result.sv
// ----------------------------------------------------------------------------
// Result stage
// Compares captured pixels with the front buffer, keeps the buffer
// sequences, and builds each result into an output register.
// ----------------------------------------------------------------------------
module lfsp_result import lfsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  tag_t               tag_i,
  input  logic [PIXEL_W-1:0] rdata_i,
  input  cfg_t               cfg_i,
  output logic               can_accept_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o
);

  logic        s1_valid_q, s1_valid_d;
  tag_t        s1_tag_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic [31:0] seq_q [2];
  logic [31:0] seq_d [2];
  logic        diff_q, diff_d;

  logic        s1_adv;
  logic        mismatch;
  logic [15:0] product;
  logic [16:0] rounded;
  logic [16:0] scaled;

  assign s1_adv       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign can_accept_o = !s1_valid_q || !out_valid_q || out_ready_i;

  // Division by 255 of a value below 2^16 as a reciprocal with correction.
  assign product  = 16'(cfg_i.base_brightness) * 16'(cfg_i.fade_level);
  assign rounded  = 17'(product) + BRIGHT_ROUND;
  assign scaled   = (rounded + (rounded >> 8) + 17'd1) >> 8;
  assign mismatch = rdata_i != s1_tag_q.rgb;

  always_comb begin
    out_d      = '0;
    seq_d[0]   = seq_q[0];
    seq_d[1]   = seq_q[1];
    diff_d     = diff_q;
    unique case (s1_tag_q.func)
      FUNC_REQUEST: begin
        out_d.ready_res    = s1_tag_q.ready_res;
        out_d.sequence_res = seq_q[s1_tag_q.front];
        out_d.epoch        = cfg_i.boot_id;
      end
      FUNC_SHOW: begin
        out_d.scaled_bright   = scaled[7:0];
        out_d.capture_started = s1_tag_q.start;
        if (s1_tag_q.start) begin
          diff_d = 1'b0;
        end
      end
      FUNC_PIXEL: begin
        if (s1_tag_q.pix_en) begin
          if (s1_tag_q.pix_last) begin
            seq_d[!s1_tag_q.front] = seq_q[s1_tag_q.front] +
              32'(!s1_tag_q.ready_before || diff_q || mismatch);
            diff_d = 1'b0;
          end else begin
            diff_d = diff_q || mismatch;
          end
        end
      end
      FUNC_READ: begin
        if (s1_tag_q.rd_hit) begin
          out_d.read_red   = rdata_i[23:16];
          out_d.read_green = rdata_i[15:8];
          out_d.read_blue  = rdata_i[7:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seq_q[0]    <= '0;
      seq_q[1]    <= '0;
      diff_q      <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        seq_q[0] <= seq_d[0];
        seq_q[1] <= seq_d[1];
        diff_q   <= diff_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_tag_q <= tag_i;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: sv/led_frame_snapshot_publisher_core.sv
// ----------------------------------------------------------------------------
// LED frame snapshot publisher core
// Double-buffered snapshot of a serpentine LED matrix for a remote viewer.
// ----------------------------------------------------------------------------
// Items enter on item_i and results leave on result_o, one result per item,
// in order. An item is one of: viewer request, show, chain-order pixel, or
// read of a published pixel. Registers are written through cfg_we_i,
// cfg_index_i and cfg_wdata_i; the user must do so only while no
// transaction is in flight, which the block does not enforce. Each item
// passes the compare stage, then the output register behind result_o. One
// item is taken every cycle while item_i.ready is high; each pixel uses the
// single write port and the single read port of the frame memory in the
// cycle it is taken; the compare stage compares it with the front buffer.
// After reset the frame memory is swept to zero, one entry a cycle, through
// 2*COLUMNS*ROWS entries; item_i.ready stays low during the sweep. Viewer,
// capture and sequence state clear at once.
// When the receiver holds result_o.ready low, one result waits in the output
// register and one item in the compare stage; item_i.ready then drops until
// the output register is taken.
// ----------------------------------------------------------------------------
module led_frame_snapshot_publisher_core import lfsp_pkg::*; #(
  parameter int COLUMNS = 32,
  parameter int ROWS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lfsp_stream_if.sink   item_i,
  lfsp_stream_if.source result_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_wdata_i
);

  localparam int DEPTH = 2 * COLUMNS * ROWS;
  localparam int AW = $clog2(DEPTH);

  cfg_t               cfg_q;
  logic               accept;
  logic               clear_busy;
  logic               can_accept;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [PIXEL_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [PIXEL_W-1:0] mem_rdata;
  tag_t               tag;
  in_item_t           item;
  out_item_t          result;

  assign item         = item_i.payload;
  assign item_i.ready = !clear_busy && can_accept;
  assign accept       = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_brightness     <= RST_BASE_BRIGHTNESS;
      cfg_q.fade_level          <= RST_FADE_LEVEL;
      cfg_q.boot_id             <= RST_BOOT_ID;
      cfg_q.request_timeout_ms  <= RST_REQUEST_TIMEOUT;
      cfg_q.publish_interval_ms <= RST_PUBLISH_INTERVAL;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE_BRIGHTNESS:  cfg_q.base_brightness     <= cfg_wdata_i[7:0];
        CFG_FADE_LEVEL:       cfg_q.fade_level          <= cfg_wdata_i[7:0];
        CFG_BOOT_ID:          cfg_q.boot_id             <= cfg_wdata_i;
        CFG_REQUEST_TIMEOUT:  cfg_q.request_timeout_ms  <= cfg_wdata_i[15:0];
        CFG_PUBLISH_INTERVAL: cfg_q.publish_interval_ms <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  lfsp_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (item),
    .cfg_i        (cfg_q),
    .clear_busy_o (clear_busy),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .tag_o        (tag)
  );

  lfsp_frame_mem #(
    .DEPTH (DEPTH)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lfsp_result u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .tag_i        (tag),
    .rdata_i      (mem_rdata),
    .cfg_i        (cfg_q),
    .can_accept_o (can_accept),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .out_item_o   (result)
  );

  assign result_o.payload = result;

endmodule

// File: test/lfsp_frame_checker.sv
// ----------------------------------------------------------------------------
// LED frame snapshot checker
// Watches the item, result and register ports of the snapshot publisher.
// Keeps its own copy of the double buffer, viewer and capture state, works
// out the result of every accepted item and compares results in order.
// ----------------------------------------------------------------------------
module lfsp_frame_checker import lfsp_pkg::*; #(
  parameter int COLUMNS = 32,
  parameter int ROWS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  logic        item_ready_i,
  input  in_item_t    item_i,
  input  logic        result_valid_i,
  input  logic        result_ready_i,
  input  out_item_t   result_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  localparam int FRAME_PIXELS = COLUMNS * ROWS;

  cfg_t               regs;
  logic [PIXEL_W-1:0] frame_mem [2*FRAME_PIXELS];
  logic               front_sel;
  logic               viewer_on;
  logic               snap_ready;
  logic               capturing;
  logic               changed;
  logic [31:0]        last_request_ms;
  logic [31:0]        last_publish_ms;
  logic [31:0]        capture_ms;
  logic [31:0]        frame_seq [2];
  int unsigned        chain_pos;
  int unsigned        mismatches;
  out_item_t          expected_q [$];

  task automatic clear_state();
    regs = '{RST_BASE_BRIGHTNESS, RST_FADE_LEVEL, RST_BOOT_ID,
             RST_REQUEST_TIMEOUT, RST_PUBLISH_INTERVAL};
    foreach (frame_mem[i]) frame_mem[i] = '0;
    front_sel       = 1'b0;
    viewer_on       = 1'b0;
    snap_ready      = 1'b0;
    capturing       = 1'b0;
    changed         = 1'b0;
    last_request_ms = '0;
    last_publish_ms = '0;
    capture_ms      = '0;
    frame_seq[0]    = '0;
    frame_seq[1]    = '0;
    chain_pos       = 0;
    mismatches      = 0;
    expected_q.delete();
  endtask

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t          res;
    logic [31:0]        since_request;
    logic [31:0]        since_publish;
    int unsigned        front_base;
    int unsigned        back_base;
    int unsigned        row;
    int unsigned        col;
    int unsigned        pos;
    logic [PIXEL_W-1:0] rgb;
    logic               start;
    res           = '0;
    front_base    = front_sel ? FRAME_PIXELS : 0;
    back_base     = front_sel ? 0 : FRAME_PIXELS;
    since_request = it.now_ms - last_request_ms;
    since_publish = it.now_ms - last_publish_ms;
    case (it.func)
      FUNC_REQUEST: begin
        if (!viewer_on || since_request > 32'(regs.request_timeout_ms)) snap_ready = 1'b0;
        viewer_on        = 1'b1;
        last_request_ms  = it.now_ms;
        res.ready_res    = snap_ready;
        res.sequence_res = frame_seq[front_sel];
        res.epoch        = regs.boot_id;
      end
      FUNC_SHOW: begin
        start = viewer_on && since_request <= 32'(regs.request_timeout_ms) &&
                (!snap_ready || since_publish >= 32'(regs.publish_interval_ms));
        res.scaled_bright =
          8'((int'(regs.base_brightness) * int'(regs.fade_level) + 127) / 255);
        // A show that qualifies also restarts a capture already running.
        if (start) begin
          capturing           = 1'b1;
          capture_ms          = it.now_ms;
          chain_pos           = 0;
          changed             = 1'b0;
          res.capture_started = 1'b1;
        end
      end
      FUNC_PIXEL: begin
        if (capturing) begin
          // The chain snakes: odd rows run right to left.
          row = chain_pos / COLUMNS;
          col = chain_pos % COLUMNS;
          if (row % 2 == 1) col = COLUMNS - 1 - col;
          pos = row * COLUMNS + col;
          rgb = {it.pixel_red, it.pixel_green, it.pixel_blue};
          if (frame_mem[front_base + pos] != rgb) changed = 1'b1;
          frame_mem[back_base + pos] = rgb;
          chain_pos++;
          if (chain_pos == FRAME_PIXELS) begin
            frame_seq[!front_sel] = frame_seq[front_sel] +
                                    ((!snap_ready || changed) ? 32'd1 : 32'd0);
            front_sel       = !front_sel;
            snap_ready      = 1'b1;
            last_publish_ms = capture_ms;
            capturing       = 1'b0;
            chain_pos       = 0;
            changed         = 1'b0;
          end
        end
      end
      default: begin
        if (int'(it.read_col) < COLUMNS && int'(it.read_row) < ROWS) begin
          rgb = frame_mem[front_base + it.read_row * COLUMNS + it.read_col];
          {res.read_red, res.read_green, res.read_blue} = rgb;
        end
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t want;
    if (!rst_ni) begin
      clear_state();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BASE_BRIGHTNESS:  regs.base_brightness     = cfg_wdata_i[7:0];
          CFG_FADE_LEVEL:       regs.fade_level          = cfg_wdata_i[7:0];
          CFG_BOOT_ID:          regs.boot_id             = cfg_wdata_i;
          CFG_REQUEST_TIMEOUT:  regs.request_timeout_ms  = cfg_wdata_i[15:0];
          CFG_PUBLISH_INTERVAL: regs.publish_interval_ms = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (item_valid_i && item_ready_i) expected_q.push_back(predict_result(item_i));
      if (result_valid_i && result_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0h", $time, result_i);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("ready_res", want.ready_res, result_i.ready_res);
          check_field("sequence_res", want.sequence_res, result_i.sequence_res);
          check_field("epoch", want.epoch, result_i.epoch);
          check_field("scaled_bright", want.scaled_bright, result_i.scaled_bright);
          check_field("capture_started", want.capture_started, result_i.capture_started);
          check_field("read_red", want.read_red, result_i.read_red);
          check_field("read_green", want.read_green, result_i.read_green);
          check_field("read_blue", want.read_blue, result_i.read_blue);
        end
      end
      mismatch_count_o <= mismatches;
      pending_count_o  <= expected_q.size();
    end
  end

endmodule

// File: test/led_frame_snapshot_publisher_core_test.sv
// ----------------------------------------------------------------------------
// LED frame snapshot publisher core test
// Drives viewer requests, shows, chain-order pixel streams and reads into
// the core under random stalls on both sides, across several register
// settings; the checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module led_frame_snapshot_publisher_core_test;
  import lfsp_pkg::*;

  localparam int COLUMNS      = 32;
  localparam int ROWS         = 8;
  localparam int FRAME_PIXELS = COLUMNS * ROWS;
  localparam int PHASES       = 3;
  localparam int PHASE_ITEMS  = 276;
  localparam int IDLE_LIMIT   = 4000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  int unsigned        mismatch_count;
  int unsigned        pending_count;
  int unsigned        items_sent;
  int unsigned        idle_cycles = 0;
  int unsigned        burst_left;
  cfg_t               active_cfg;
  logic [31:0]        clock_ms;
  logic [31:0]        last_show_ms;
  logic [PIXEL_W-1:0] chain_frame [FRAME_PIXELS];

  lfsp_stream_if #(.T(in_item_t))  item_if ();
  lfsp_stream_if #(.T(out_item_t)) result_if ();

  always #2 clk_i = ~clk_i;

  led_frame_snapshot_publisher_core #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .item_i(item_if),
    .result_o(result_if),
    .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  lfsp_frame_checker #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_checker (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .item_valid_i(item_if.valid),
    .item_ready_i(item_if.ready),
    .item_i(item_if.payload),
    .result_valid_i(result_if.valid),
    .result_ready_i(result_if.ready),
    .result_i(result_if.payload),
    .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .mismatch_count_o(mismatch_count),
    .pending_count_o(pending_count)
  );

  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t random_item(func_e f, logic [31:0] now);
    in_item_t it;
    it.func        = f;
    it.now_ms      = now;
    it.pixel_red   = 8'($urandom);
    it.pixel_green = 8'($urandom);
    it.pixel_blue  = 8'($urandom);
    it.read_col    = 5'($urandom);
    it.read_row    = 3'($urandom);
    return it;
  endfunction

  function automatic logic [PIXEL_W-1:0] random_rgb();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] time_step();
    case ($urandom_range(0, 19))
      0:       return $urandom;
      1:       return 32'(active_cfg.request_timeout_ms) + 32'd1;
      2:       return 32'd70000;
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  function automatic logic [31:0] show_delay();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'(active_cfg.request_timeout_ms);
      2:       return 32'(active_cfg.request_timeout_ms) + 32'd1;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  // Sender side: bursts without gaps alternate with random gaps.
  task automatic push_item(input in_item_t it);
    int unsigned idle;
    idle = 0;
    if (burst_left != 0) burst_left--;
    else if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(30, 300);
    else if ($urandom_range(0, 2) == 0) idle = gap_len();
    if (idle != 0) begin
      item_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    item_if.valid   <= 1'b1;
    item_if.payload <= it;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send(input func_e f, input logic [31:0] now);
    push_item(random_item(f, now));
  endtask

  task automatic send_pixel(input logic [PIXEL_W-1:0] rgb);
    in_item_t it;
    it = random_item(FUNC_PIXEL, $urandom);
    {it.pixel_red, it.pixel_green, it.pixel_blue} = rgb;
    push_item(it);
  endtask

  task automatic send_read(input logic [4:0] col, input logic [2:0] row);
    in_item_t it;
    it          = random_item(FUNC_READ, $urandom);
    it.read_col = col;
    it.read_row = row;
    push_item(it);
  endtask

  // Waits until every result is in and the pipeline has emptied.
  task automatic drain();
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  task automatic load_registers(input cfg_t c);
    item_if.valid <= 1'b0;
    drain();
    put_reg(CFG_BASE_BRIGHTNESS, 32'(c.base_brightness));
    put_reg(CFG_FADE_LEVEL, 32'(c.fade_level));
    put_reg(CFG_BOOT_ID, c.boot_id);
    put_reg(CFG_REQUEST_TIMEOUT, 32'(c.request_timeout_ms));
    put_reg(CFG_PUBLISH_INTERVAL, 32'(c.publish_interval_ms));
    cfg_we     <= 1'b0;
    active_cfg  = c;
  endtask

  // Request, show, then a whole or partial chain of pixels. The content is
  // fresh, a repeat of the last chain, or a repeat with one pixel changed,
  // so that publishes both with and without a sequence step occur.
  task automatic capture_episode(input int unsigned room);
    int unsigned count;
    int unsigned mode;
    int unsigned changed_at;
    logic [31:0] show_ms;
    clock_ms += time_step();
    send(FUNC_REQUEST, clock_ms);
    if ($urandom_range(0, 3) == 0) send(FUNC_READ, $urandom);
    show_ms = clock_ms + show_delay();
    send(FUNC_SHOW, show_ms);
    last_show_ms = show_ms;
    clock_ms     = show_ms;
    count      = ($urandom_range(0, 4) == 0) ? $urandom_range(1, FRAME_PIXELS - 1)
                                             : FRAME_PIXELS;
    // Keep the phase close to its share of items.
    if (count + 8 > room) count = (room > 8) ? room - 8 : 1;
    mode       = $urandom_range(0, 2);
    changed_at = $urandom_range(0, FRAME_PIXELS - 1);
    for (int unsigned i = 0; i < count; i++) begin
      if (mode == 0 || (mode == 2 && i == changed_at)) chain_frame[i] = random_rgb();
      if ($urandom_range(0, 63) == 0) send(FUNC_READ, $urandom);
      if ($urandom_range(0, 199) == 0) send(FUNC_REQUEST, clock_ms);
      send_pixel(chain_frame[i]);
    end
    repeat ($urandom_range(1, 3)) send(FUNC_READ, $urandom);
  endtask

  // Show right at, or one short of, the publish interval after the last show.
  task automatic interval_episode();
    logic [31:0] show_ms;
    show_ms = last_show_ms + 32'(active_cfg.publish_interval_ms) - $urandom_range(0, 1);
    send(FUNC_REQUEST, show_ms - $urandom_range(0, 3));
    send(FUNC_SHOW, show_ms);
    repeat ($urandom_range(0, 4)) send_pixel(random_rgb());
    send(FUNC_READ, $urandom);
  endtask

  task automatic noise_episode();
    repeat ($urandom_range(1, 8)) begin
      send(func_e'(2'($urandom_range(0, 3))),
           ($urandom_range(0, 3) == 0) ? $urandom : clock_ms + $urandom_range(0, 500));
    end
  endtask

  initial begin : result_sink
    int unsigned run;
    result_if.ready = 1'b0;
    run = 0;
    forever begin
      @(posedge clk_i);
      if (run != 0) begin
        run--;
      end else if (result_if.ready) begin
        result_if.ready <= 1'b0;
        run = gap_len() - 1;
      end else begin
        result_if.ready <= 1'b1;
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 30);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    cfg_t        setting;
    int unsigned phase_start;
    int unsigned room;
    int unsigned pick;
    item_if.valid   = 1'b0;
    item_if.payload = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    items_sent      = 0;
    burst_left      = 0;
    clock_ms        = '0;
    last_show_ms    = '0;
    active_cfg      = '{RST_BASE_BRIGHTNESS, RST_FADE_LEVEL, RST_BOOT_ID,
                        RST_REQUEST_TIMEOUT, RST_PUBLISH_INTERVAL};
    foreach (chain_frame[i]) chain_frame[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with the registers at their reset values.
    send_read(5'd0, 3'd0);
    send_read(5'd31, 3'd7);
    send(FUNC_SHOW, 32'd0);              // no viewer yet, so no capture
    send_pixel('1);                      // dropped while no capture runs
    send(FUNC_REQUEST, 32'd0);
    send(FUNC_SHOW, 32'd5000);           // exactly at the timeout
    send_pixel('1);
    send_pixel('0);
    send_pixel(24'hA55AC3);
    send(FUNC_SHOW, 32'd5001);           // one past the timeout: capture goes on
    send_pixel(24'h5AA53C);
    send(FUNC_REQUEST, 32'd10002);       // viewer has timed out
    send(FUNC_SHOW, 32'd10002);          // restarts the running capture
    send_pixel(24'h123456);
    send(FUNC_REQUEST, 32'hFFFF_FFFF);
    send(FUNC_REQUEST, 32'h0000_0010);   // time wrapped past zero
    send(FUNC_SHOW, 32'h0000_0010);
    send_pixel(24'hFF00FF);
    send_read(5'd31, 3'd0);
    send_read(5'd0, 3'd7);
    send_read(5'd31, 3'd7);
    clock_ms     = 32'h0000_0010;
    last_show_ms = 32'h0000_0010;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       setting = '{8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF};
        1:       setting = '0;
        default: setting = '{8'($urandom), 8'($urandom), $urandom,
                             16'($urandom), 16'($urandom_range(0, 600))};
      endcase
      load_registers(setting);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        room = PHASE_ITEMS - (items_sent - phase_start);
        pick = $urandom_range(0, 9);
        if (pick < 6) capture_episode(room);
        else if (pick < 8) interval_episode();
        else noise_episode();
      end
    end

    item_if.valid <= 1'b0;
    drain();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
